// ===== hdl/positional_list_store_unit_assert.svh =====
// Assertion macros for the positional list store.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define PLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define PLS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PLS_ASSERT(label, clk, rst_n, prop, msg)
`define PLS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== hdl/pls_pkg.sv =====
// Shared constants, codes and controller/datapath structs of the positional list store.
// No dependencies.
package pls_pkg;

  localparam int Depth   = 16;
  localparam int DataW   = 32;
  localparam int KindW   = 3;
  localparam int ValueW  = 32;
  localparam int PosW    = 5;
  localparam int StatusW = 2;
  localparam int CountW  = 5;
  localparam int CntW    = $clog2(Depth + 1);
  localparam int IdxW    = $clog2(Depth);
  localparam int CmpW    = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic [KindW-1:0] {
    KIND_INS_FIRST = 3'd0,
    KIND_INS_LAST  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_LAST  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_DUMP      = 3'd6
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_req;   // capture the accepted request
    logic exec_op;     // apply the operation and load its status result
    logic dump_load;   // load the next dumped entry as a result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;       // result register can take a new result this cycle
    logic dump_nonempty;  // latched request is a dump of a non-empty list
    logic dump_last;      // the current dump entry is the final one
  } stat_t;

endpackage

// ===== hdl/pls_if.sv =====
// Request and result channel interfaces of the positional list store.
// Depends on pls_pkg for field widths.
interface pls_req_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [KindW-1:0]  kind;
  logic signed [ValueW-1:0] value;
  logic        [PosW-1:0]   position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [StatusW-1:0] status;
  logic        [CountW-1:0]  count;
  logic                      has_element;
  logic signed [ValueW-1:0]  element;
  logic                      is_last;

  modport source (output valid, status, count, has_element, element, is_last, input ready);
  modport sink   (input valid, status, count, has_element, element, is_last, output ready);
endinterface

// ===== hdl/pls_datapath.sv =====
// Datapath of the positional list store: request register, entry shift array,
// count, dump index and result register. Depends on pls_pkg and the assert macros.
`include "positional_list_store_unit_assert.svh"

module pls_datapath import pls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  logic        [KindW-1:0]   kind_i,
  input  logic signed [ValueW-1:0]  value_i,
  input  logic        [PosW-1:0]    position_i,
  input  logic                      rsp_ready_i,
  output logic                      rsp_valid_o,
  output logic        [StatusW-1:0] rsp_status_o,
  output logic        [CountW-1:0]  rsp_count_o,
  output logic                      rsp_has_element_o,
  output logic signed [ValueW-1:0]  rsp_element_o,
  output logic                      rsp_is_last_o
);

  logic        [KindW-1:0]  kind_q;
  logic signed [DataW-1:0]  value_q;
  logic        [PosW-1:0]   pos_q;
  logic        [CntW-1:0]   count_q, count_d;
  logic        [IdxW-1:0]   idx_q;
  logic signed [DataW-1:0]  entries_q [Depth];
  logic                     out_valid_q;
  logic        [StatusW-1:0] out_status_q;
  logic        [CountW-1:0]  out_count_q;
  logic                      out_has_q;
  logic signed [ValueW-1:0]  out_elem_q;
  logic                      out_last_q;

  logic                do_ins, do_del;
  logic [IdxW-1:0]     tgt;
  status_e             op_status;
  logic                full, empty;
  logic [CmpW-1:0]     pos_c, cnt_c;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);
  assign pos_c = CmpW'(pos_q);
  assign cnt_c = CmpW'(count_q);

  // Decode the latched request into a shift direction and a target slot.
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    tgt       = '0;
    op_status = STATUS_OK;
    case (kind_e'(kind_q))
      KIND_INS_FIRST: begin
        if (full) op_status = STATUS_FULL;
        else do_ins = 1'b1;
      end
      KIND_INS_LAST: begin
        if (full) op_status = STATUS_FULL;
        else begin
          do_ins = 1'b1;
          tgt    = IdxW'(count_q);
        end
      end
      KIND_INS_AT: begin
        if (full) op_status = STATUS_FULL;
        else if (pos_c == '0 || pos_c > cnt_c + CmpW'(1)) op_status = STATUS_BAD_POS;
        else begin
          do_ins = 1'b1;
          tgt    = IdxW'(pos_c - CmpW'(1));
        end
      end
      KIND_DEL_FIRST: begin
        if (empty) op_status = STATUS_EMPTY;
        else do_del = 1'b1;
      end
      KIND_DEL_LAST: begin
        if (empty) op_status = STATUS_EMPTY;
        else begin
          do_del = 1'b1;
          tgt    = IdxW'(count_q - CntW'(1));
        end
      end
      KIND_DEL_AT: begin
        if (empty) op_status = STATUS_EMPTY;
        else if (pos_c == '0 || pos_c > cnt_c) op_status = STATUS_BAD_POS;
        else begin
          do_del = 1'b1;
          tgt    = IdxW'(pos_c - CmpW'(1));
        end
      end
      KIND_DUMP: op_status = STATUS_OK;
      default:   op_status = STATUS_BAD_POS;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.exec_op && do_ins) count_d = count_q + CntW'(1);
    else if (cmd_i.exec_op && do_del) count_d = count_q - CntW'(1);
  end

  assign stat_o.out_free      = !out_valid_q || rsp_ready_i;
  assign stat_o.dump_nonempty = (kind_q == KIND_DUMP) && !empty;
  assign stat_o.dump_last     = ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      kind_q  <= kind_i;
      value_q <= DataW'(value_i);
      pos_q   <= position_i;
    end
  end

  // Each entry takes its neighbor below on an insert and above on a delete.
  for (genvar g = 0; g < Depth; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec_op && do_ins) begin
        if (IdxW'(g) == tgt) begin
          entries_q[g] <= value_q;
        end else if (g > 0 && IdxW'(g) > tgt && CntW'(g) <= count_q) begin
          entries_q[g] <= entries_q[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd_i.exec_op && do_del) begin
        if (g < Depth - 1 && IdxW'(g) >= tgt && CntW'(g + 1) < count_q) begin
          entries_q[g] <= entries_q[(g < Depth - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.latch_req) idx_q <= '0;
      else if (cmd_i.dump_load) idx_q <= idx_q + IdxW'(1);
      if (cmd_i.exec_op || cmd_i.dump_load) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_op) begin
      out_status_q <= op_status;
      out_count_q  <= CountW'(count_d);
      out_has_q    <= 1'b0;
      out_elem_q   <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.dump_load) begin
      out_status_q <= STATUS_OK;
      out_count_q  <= CountW'(count_q);
      out_has_q    <= 1'b1;
      out_elem_q   <= ValueW'(entries_q[idx_q]);
      out_last_q   <= stat_o.dump_last;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = out_status_q;
  assign rsp_count_o       = out_count_q;
  assign rsp_has_element_o = out_has_q;
  assign rsp_element_o     = out_elem_q;
  assign rsp_is_last_o     = out_last_q;

  `PLS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "count exceeds depth")
  `PLS_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
      out_valid_q && !rsp_ready_i && (cmd_i.exec_op || cmd_i.dump_load),
      "result overwritten before it was taken")
  `PLS_ASSERT_NEVER(a_dump_nonempty, clk_i, rst_ni, cmd_i.dump_load && empty,
      "dump entry loaded from an empty list")
  `PLS_ASSERT(a_count_stable, clk_i, rst_ni, !cmd_i.exec_op |=> $stable(count_q),
      "count changed without an operation")

endmodule

// ===== hdl/pls_ctrl.sv =====
// Controller of the positional list store: accepts requests and sequences
// operations and dump results. Depends on pls_pkg.
module pls_ctrl import pls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DUMP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          if (stat_i.dump_nonempty) begin
            cmd_o.dump_load = 1'b1;
            state_d         = stat_i.dump_last ? ST_IDLE : ST_DUMP;
          end else begin
            cmd_o.exec_op = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.dump_load = 1'b1;
          if (stat_i.dump_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/positional_list_store_unit.sv =====
// A request is captured in the request register; the execute state then registers its result.
// A new request is taken only in idle, after the last result or dump entry has been loaded.
// A stalled result register holds the controller in its execute or dump state.
// Reset: asynchronous, active low; the list is empty, storage is not cleared.
// Top level of the positional list store; depends on pls_pkg, the interfaces,
// pls_ctrl and pls_datapath.
module positional_list_store_unit import pls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pls_req_if.sink   req_i,
  pls_rsp_if.source rsp_o
);

  // The controller decides when a request is taken and when a result is loaded.
  // The datapath holds the list as a row of registers that all shift together
  // on an insert or a delete, so every edit is applied when the execute state issues it.
  // A dump walks an index over the live entries, one result per cycle, as long
  // as the result register is free or being emptied.

  cmd_t  cmd;
  stat_t stat;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The result register sits between the datapath and the result channel, so
  // a new request is accepted while an earlier result still waits.
  pls_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (req_i.kind),
    .value_i           (req_i.value),
    .position_i        (req_i.position),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_status_o      (rsp_o.status),
    .rsp_count_o       (rsp_o.count),
    .rsp_has_element_o (rsp_o.has_element),
    .rsp_element_o     (rsp_o.element),
    .rsp_is_last_o     (rsp_o.is_last)
  );

endmodule

// ===== tb/sv/list_store_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the positional list store: keeps its own copy of the list,
// predicts the results of each accepted request and compares every result taken.
// Depends on pls_pkg and the request and result channel interfaces.
module list_store_checker import pls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pls_req_if          req_i,
  pls_rsp_if          rsp_i,
  output int unsigned fails_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
    logic              has_element;
    logic [ValueW-1:0] element;
    logic              is_last;
  } reply_t;

  reply_t                  expected_replies[$];
  logic signed [DataW-1:0] list_copy[Depth];
  int unsigned             list_len = 0;
  int unsigned             fails    = 0;
  int unsigned             results  = 0;

  // Every operation other than a non-empty dump answers with one of these.
  function automatic reply_t status_reply(status_e st);
    reply_t r;
    r.status      = st;
    r.count       = CountW'(list_len);
    r.has_element = 1'b0;
    r.element     = '0;
    r.is_last     = 1'b1;
    return r;
  endfunction

  function automatic void put_entry(int unsigned idx, logic [ValueW-1:0] v);
    for (int unsigned i = list_len; i > idx; i--) list_copy[i] = list_copy[i-1];
    list_copy[idx] = DataW'(v);
    list_len++;
  endfunction

  function automatic void take_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) list_copy[i] = list_copy[i+1];
    list_len--;
  endfunction

  task automatic apply_request(logic [KindW-1:0] kind, logic [ValueW-1:0] value,
                               logic [PosW-1:0] pos);
    reply_t  r;
    status_e st;
    st = STATUS_OK;
    case (kind)
      KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
        // A full list refuses every insert before the position is looked at.
        if (list_len >= Depth) st = STATUS_FULL;
        else if (kind == KIND_INS_FIRST) put_entry(0, value);
        else if (kind == KIND_INS_LAST) put_entry(list_len, value);
        else if (pos == 0 || pos > list_len + 1) st = STATUS_BAD_POS;
        else put_entry(pos - 1, value);
      end
      KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT: begin
        if (list_len == 0) st = STATUS_EMPTY;
        else if (kind == KIND_DEL_FIRST) take_entry(0);
        else if (kind == KIND_DEL_LAST) take_entry(list_len - 1);
        else if (pos == 0 || pos > list_len) st = STATUS_BAD_POS;
        else take_entry(pos - 1);
      end
      KIND_DUMP: begin
        for (int unsigned i = 0; i < list_len; i++) begin
          r             = status_reply(STATUS_OK);
          r.has_element = 1'b1;
          r.element     = ValueW'(list_copy[i]);
          r.is_last     = (i + 1 == list_len);
          expected_replies.push_back(r);
        end
      end
      default: st = STATUS_BAD_POS;
    endcase
    // An empty dump gives a lone result that looks like a plain status.
    if (kind != KIND_DUMP || list_len == 0) expected_replies.push_back(status_reply(st));
  endtask

  task automatic check_field(string name, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic take_result();
    reply_t want;
    results++;
    if (expected_replies.size() == 0) begin
      fails++;
      $display("%0t: result with nothing expected, got status %0d count %0d element 0x%0h",
               $time, rsp_i.status, rsp_i.count, rsp_i.element);
    end else begin
      want = expected_replies.pop_front();
      check_field("status", want.status, rsp_i.status);
      check_field("count", want.count, rsp_i.count);
      check_field("has_element", want.has_element, rsp_i.has_element);
      check_field("element", want.element, rsp_i.element);
      check_field("is_last", want.is_last, rsp_i.is_last);
    end
  endtask

  // Results are taken before the request of the same edge is predicted, so
  // a fresh expectation never meets a result in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) take_result();
      if (req_i.valid && req_i.ready) apply_request(req_i.kind, req_i.value, req_i.position);
    end
    fails_o   <= fails;
    pending_o <= expected_replies.size();
    results_o <= results;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the positional list store testbench: clock, reset, request stimulus and
// result back-pressure; list_store_checker predicts and judges every result.
// Depends on pls_pkg, the channel interfaces, list_store_checker and the unit.
module tb;
  import pls_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietCycles = 20;
  localparam int unsigned RoundCount  = 10;
  localparam int unsigned RoundItems  = 40;
  // The kind field has room for one code that names no operation.
  localparam logic [KindW-1:0] KindUnused = 3'd7;

  // Operation mixes of the random rounds, from filling the list to draining it.
  typedef enum logic [1:0] {MIX_FILL, MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  // Set by the stimulus to ask the result side for one long hold-off.
  logic        hold_ask    = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned sent_count  = 0;
  int unsigned dump_count  = 0;
  int unsigned full_count  = 0;
  // Size of the list once every accepted request has been applied. It only
  // steers the choice of positions toward valid ones and counts inserts into a full list.
  int unsigned list_size   = 0;
  int unsigned cycle_count = 0;

  pls_req_if req_ch ();
  pls_rsp_if rsp_ch ();

  positional_list_store_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  list_store_checker list_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_ch),
    .rsp_i     (rsp_ch),
    .fails_o   (fail_count),
    .pending_o (pending_count),
    .results_o (result_count)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offers one request and returns at the edge where it is accepted. The valid
  // stays high, so the caller either sends the next request right away or
  // drops valid for a gap.
  task automatic send(logic [KindW-1:0] kind, logic [ValueW-1:0] value,
                      logic [PosW-1:0] pos);
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= kind;
    req_ch.value    <= value;
    req_ch.position <= pos;
    do @(posedge clk_i); while (!req_ch.ready);
    sent_count++;
    case (kind)
      KIND_INS_FIRST, KIND_INS_LAST: begin
        if (list_size < Depth) list_size++;
        else full_count++;
      end
      KIND_INS_AT: begin
        if (list_size >= Depth) full_count++;
        else if (pos != 0 && pos <= list_size + 1) list_size++;
      end
      KIND_DEL_FIRST, KIND_DEL_LAST: begin
        if (list_size > 0) list_size--;
      end
      KIND_DEL_AT: begin
        if (list_size > 0 && pos != 0 && pos <= list_size) list_size--;
      end
      KIND_DUMP: dump_count++;
      default: ;
    endcase
  endtask

  // Most gaps are short; a few are long enough to let the unit run dry.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic idle_after(int unsigned gap);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Values lean toward the extremes of the signed range now and then.
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(ValueW-1){1'b0}}};
      3:       return {1'b0, {(ValueW-1){1'b1}}};
      default: return ValueW'($urandom);
    endcase
  endfunction

  // A position is mostly valid for the current size. The rest are just past
  // the end, zero, or anything the field can hold.
  function automatic logic [PosW-1:0] pick_position(int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80 && limit != 0) return PosW'($urandom_range(1, limit));
    if (r < 90) return ($urandom_range(0, 1) != 0) ? PosW'(limit + 1) : '0;
    return PosW'($urandom_range(0, (1 << PosW) - 1));
  endfunction

  task automatic send_random(mix_e mix);
    int unsigned      r;
    int unsigned      ins_top;
    int unsigned      del_top;
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  pos;
    case (mix)
      MIX_FILL: begin ins_top = 90; del_top = 94; end
      MIX_GROW: begin ins_top = 65; del_top = 86; end
      MIX_EVEN: begin ins_top = 42; del_top = 84; end
      default:  begin ins_top = 18; del_top = 86; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_top) kind = KindW'($urandom_range(KIND_INS_FIRST, KIND_INS_AT));
    else if (r < del_top) kind = KindW'($urandom_range(KIND_DEL_FIRST, KIND_DEL_AT));
    else if (r < 98) kind = KIND_DUMP;
    else kind = KindUnused;
    if (kind == KIND_INS_AT) pos = pick_position(list_size + 1);
    else if (kind == KIND_DEL_AT) pos = pick_position(list_size);
    else pos = PosW'($urandom);
    send(kind, pick_value(), pos);
  endtask

  // Drops valid and waits until the checker has no result left to wait for.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Result side: ready comes in random runs and stalls, mostly short, with a
  // few long stalls and long stretches of steady ready. When asked, it holds
  // ready low for a long, counted stretch while requests keep coming, so the
  // result register backs up and the unit stops taking requests.
  initial begin : result_sink
    int unsigned span;
    rsp_ch.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0:          span = $urandom_range(60, 150);
          1, 2, 3, 4: span = $urandom_range(7, 30);
          default:    span = $urandom_range(1, 6);
        endcase
        do begin
          @(posedge clk_i);
          span--;
        end while (span != 0 && !hold_ask);
        if (!hold_ask) begin
          rsp_ch.ready <= 1'b0;
          case ($urandom_range(0, 19))
            0:          span = $urandom_range(15, 40);
            1, 2, 3, 4: span = $urandom_range(3, 6);
            default:    span = $urandom_range(1, 2);
          endcase
          repeat (span) @(posedge clk_i);
        end
      end
    end
  end

  // The run is cut off if it goes on far beyond the slowest correct run.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycle_count, pending_count);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    mix_e        mix;
    int unsigned round;
    req_ch.valid    = 1'b0;
    req_ch.kind     = KIND_INS_FIRST;
    req_ch.value    = '0;
    req_ch.position = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, back to back. It starts on the empty list: a dump gives a
    // single result with no element, every delete kind reports empty (delete at
    // a position included), and inserts at position zero or past the end are
    // ignored as bad positions.
    send(KIND_DUMP, '0, '0);
    send(KIND_DEL_FIRST, '0, '0);
    send(KIND_DEL_LAST, '0, '0);
    send(KIND_DEL_AT, '0, 5'd3);
    send(KIND_INS_AT, 32'h1234_5678, 5'd0);
    send(KIND_INS_AT, 32'h1234_5678, 5'd2);
    // Build a list from the extremes of the value range, inserting at the
    // front, the back, just past the end and in the middle.
    send(KIND_INS_AT, 32'h8000_0000, 5'd1);
    send(KIND_INS_FIRST, 32'h7FFF_FFFF, '0);
    send(KIND_INS_LAST, 32'hFFFF_FFFF, '0);
    send(KIND_INS_AT, 32'h0000_0000, 5'd4);
    send(KIND_INS_AT, 32'h5A5A_A5A5, 5'd2);
    send(KIND_DUMP, '0, '0);
    // Bad positions on a non-empty list leave it as it is; a valid delete at 3 and an unused kind follow.
    send(KIND_DEL_AT, '0, 5'd6);
    send(KIND_DEL_AT, '0, 5'd0);
    send(KIND_INS_AT, 32'hDEAD_BEEF, 5'd31);
    send(KIND_DEL_AT, '0, 5'd3);
    send(KindUnused, 32'hFFFF_FFFF, 5'd31);
    // Shrink to nothing; the last delete removes the only entry.
    send(KIND_DEL_LAST, '0, '0);
    send(KIND_DEL_FIRST, '0, '0);
    send(KIND_DEL_AT, '0, 5'd2);
    send(KIND_DEL_AT, '0, 5'd1);
    send(KIND_DUMP, '0, '0);

    // Random rounds. Fill rounds push the list to full and into refused
    // inserts, shrink rounds drain it to empty. Round 4 runs without gaps and
    // then waits for every result; round 6 runs without gaps against a long
    // hold-off of the result side.
    for (round = 0; round < RoundCount; round++) begin
      case (round)
        0, 6:    mix = MIX_FILL;
        3, 9:    mix = MIX_GROW;
        2, 5, 8: mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      if (round == 6) hold_ask = 1'b1;
      repeat (RoundItems) begin
        send_random(mix);
        if (round != 4 && round != 6) idle_after(pick_gap());
      end
      if (round == 4) begin
        wait_drained();
        repeat ($urandom_range(5, 25)) @(posedge clk_i);
      end
    end

    wait_drained();
    repeat (QuietCycles) @(posedge clk_i);
    $display("Run covered %0d requests, %0d of them dumps and %0d inserts into a full list,",
             sent_count, dump_count, full_count);
    $display("and checked %0d results field by field.", result_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
